FILE: rtl/aalu_pkg.sv
package aalu_pkg;

  // Operation codes
  localparam logic [3:0] FUNC_ADD = 4'd0;
  localparam logic [3:0] FUNC_ADC = 4'd1;
  localparam logic [3:0] FUNC_SUB = 4'd2;
  localparam logic [3:0] FUNC_SBC = 4'd3;
  localparam logic [3:0] FUNC_AND = 4'd4;
  localparam logic [3:0] FUNC_XOR = 4'd5;
  localparam logic [3:0] FUNC_CP  = 4'd6;
  localparam logic [3:0] FUNC_INC = 4'd7;
  localparam logic [3:0] FUNC_DEC = 4'd8;
  localparam logic [3:0] FUNC_CPL = 4'd9;
  localparam logic [3:0] FUNC_SCF = 4'd10;
  localparam logic [3:0] FUNC_CCF = 4'd11;

  // Flag bit positions: Z N H C
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] operand;
  } aalu_in_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] incdec_value;
    logic [3:0] flags_out;
    logic       bad_code;
  } aalu_out_t;

  // Handshake control between the control unit and the datapath
  typedef struct packed {
    logic load_in;  // capture a new transaction into the input register
    logic advance;  // move the input-register transaction to the result register
  } aalu_ctrl_t;

endpackage

FILE: rtl/aalu_core.sv
module aalu_core (
  input  aalu_pkg::aalu_in_t  item,
  input  logic [7:0]          acc,
  input  logic [3:0]          flags,
  output logic [7:0]          acc_nxt,
  output logic [3:0]          flags_nxt,
  output aalu_pkg::aalu_out_t result
);
  import aalu_pkg::*;

  logic [7:0] b;
  logic       cin;
  logic       c_use;
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] dif9;
  logic [4:0] dif5;
  logic [7:0] and_v;
  logic [7:0] xor_v;
  logic [7:0] inc_v;
  logic [7:0] dec_v;
  logic [7:0] idv;
  logic       bad;

  assign b     = item.operand;
  assign cin   = flags[FLAG_C];
  assign c_use = cin & ((item.func == FUNC_ADC) | (item.func == FUNC_SBC));

  assign sum9  = {1'b0, acc} + {1'b0, b} + {8'b0, c_use};
  assign sum5  = {1'b0, acc[3:0]} + {1'b0, b[3:0]} + {4'b0, c_use};
  // borrow shows up in the top bit of the wrapped difference
  assign dif9  = {1'b0, acc} - {1'b0, b} - {8'b0, c_use};
  assign dif5  = {1'b0, acc[3:0]} - {1'b0, b[3:0]} - {4'b0, c_use};
  assign and_v = acc & b;
  assign xor_v = acc ^ b;
  assign inc_v = b + 8'd1;
  assign dec_v = b - 8'd1;

  always_comb begin
    acc_nxt   = acc;
    flags_nxt = flags;
    idv       = 8'd0;
    bad       = 1'b0;
    unique case (item.func)
      FUNC_ADD, FUNC_ADC: begin
        acc_nxt   = sum9[7:0];
        flags_nxt = {(sum9[7:0] == 8'd0), 1'b0, sum5[4], sum9[8]};
      end
      FUNC_SUB, FUNC_SBC: begin
        acc_nxt   = dif9[7:0];
        flags_nxt = {(dif9[7:0] == 8'd0), 1'b1, dif5[4], dif9[8]};
      end
      FUNC_CP: begin
        flags_nxt = {(dif9[7:0] == 8'd0), 1'b1, dif5[4], dif9[8]};
      end
      FUNC_AND: begin
        acc_nxt   = and_v;
        flags_nxt = {(and_v == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      FUNC_XOR: begin
        acc_nxt   = xor_v;
        flags_nxt = {(xor_v == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      FUNC_INC: begin
        idv       = inc_v;
        flags_nxt = {(inc_v == 8'd0), 1'b0, (b[3:0] == 4'hF), cin};
      end
      FUNC_DEC: begin
        idv       = dec_v;
        flags_nxt = {(dec_v == 8'd0), 1'b1, (b[3:0] == 4'h0), cin};
      end
      FUNC_CPL: begin
        acc_nxt   = ~acc;
        flags_nxt = {flags[FLAG_Z], 1'b1, 1'b1, cin};
      end
      FUNC_SCF: flags_nxt = {flags[FLAG_Z], 1'b0, 1'b0, 1'b1};
      FUNC_CCF: flags_nxt = {flags[FLAG_Z], 1'b0, 1'b0, ~cin};
      default:  bad = 1'b1;  // unused code: state kept
    endcase
  end

  assign result.acc_out      = acc_nxt;
  assign result.incdec_value = idv;
  assign result.flags_out    = flags_nxt;
  assign result.bad_code     = bad;

endmodule

FILE: rtl/aalu_ctrl.sv
module aalu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_stall,
  output logic                 in_stall,
  output logic                 out_valid,
  output aalu_pkg::aalu_ctrl_t ctrl
);
  import aalu_pkg::*;

  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  // result register frees up when empty or taken this cycle
  assign ctrl.advance = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall     = s1_valid_r & ~ctrl.advance;
  assign ctrl.load_in = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (ctrl.load_in) begin
      s1_valid_nxt = 1'b1;
    end else if (ctrl.advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (ctrl.advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/accumulator_alu_with_flags_unit.sv
// Eight-bit accumulator ALU with zero, subtract, half-carry and carry flags.
// Input channel (in_valid / in_stall / in_data): one transaction carries an
//   operation code and an operand byte. It is taken at a rising edge with
//   in_valid high and in_stall low.
// Result channel (out_valid / out_stall / out_data): one result transaction
//   per input transaction, in order: new accumulator, inc/dec value, flags
//   and the unused-code mark.
// Pipeline: input register, then one pass through the ALU into the result
//   register, where the accumulator and flags are updated on the same edge
//   as out_valid rises.
// Throughput: one transaction per cycle while no stall holds the result;
//   the accumulator/flag feedback loop closes inside that single ALU pass,
//   so back-to-back items chain directly.
// Stall: while out_stall holds a pending result, one more transaction may
//   sit in the input register; after that in_stall rises until the result
//   is taken. No transaction is dropped or repeated.
// Reset (rst_n low, synchronous): accumulator and flags clear to zero and
//   both pipeline stages empty.
module accumulator_alu_with_flags_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aalu_pkg::aalu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aalu_pkg::aalu_out_t out_data
);
  import aalu_pkg::*;

  aalu_ctrl_t ctrl;
  aalu_in_t   s1_item_r;
  aalu_out_t  out_data_r;
  aalu_out_t  result;
  logic [7:0] acc_r;
  logic [7:0] acc_nxt;
  logic [3:0] flags_r;
  logic [3:0] flags_nxt;

  aalu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  aalu_core u_core (
    .item      (s1_item_r),
    .acc       (acc_r),
    .flags     (flags_r),
    .acc_nxt   (acc_nxt),
    .flags_nxt (flags_nxt),
    .result    (result)
  );

  // Input register: payload only
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      s1_item_r <= in_data;
    end
  end

  // Result register: payload only, held while stalled
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      out_data_r <= result;
    end
  end

  // Architectural state commits as the transaction leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'd0;
      flags_r <= 4'd0;
    end else if (ctrl.advance) begin
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_data = out_data_r;

  // The input side stalls only when a transaction waits in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !ctrl.advance)
    else $error("in_stall raised while input stage advances");

  // A transaction that advances is presented on the result channel next cycle
  a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance |=> out_valid)
    else $error("advanced transaction missing on result channel");

  // An unused code leaves accumulator and flags untouched
  a_bad_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.advance && result.bad_code) |=>
      (acc_r == $past(acc_r)) && (flags_r == $past(flags_r)))
    else $error("unused code changed state");

  // Result register mirrors the committed state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ctrl.advance) |-> (out_data.acc_out == acc_r) && (out_data.flags_out == flags_r))
    else $error("result disagrees with committed state");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import aalu_pkg::*;

  // Codes 12..15 have no operation behind them
  localparam logic [3:0] FUNC_RSV12 = 4'd12;
  localparam logic [3:0] FUNC_RSV13 = 4'd13;
  localparam logic [3:0] FUNC_RSV14 = 4'd14;
  localparam logic [3:0] FUNC_RSV15 = 4'd15;

  localparam int RANDOM_OPS   = 1850;
  localparam int DRAIN_AT     = 900;   // mid-run pause until the pipe is empty
  localparam int TAIL_CYCLES  = 8;     // margin after the final drain
  localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  aalu_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  aalu_out_t out_data;

  accumulator_alu_with_flags_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // Directed table. Rows with 'typed' set carry a hand-derived result;
  // the rest are checked against the ALU model below.
  // ---------------------------------------------------------------------
  typedef struct {
    aalu_in_t  op;
    bit        typed;
    aalu_out_t want;
  } op_row_t;

  op_row_t   op_table[$];
  aalu_out_t result_q[$];   // expected results, oldest first
  int        n_taken;       // input transactions accepted so far
  int        n_errors;
  int        burst_left;

  // ALU model state
  logic [7:0] acc_q;
  logic [3:0] flag_q;

  task automatic add_row(input logic [3:0] f, input logic [7:0] opnd, input bit typed,
                         input logic [7:0] acc, input logic [7:0] idv,
                         input logic [3:0] fl, input logic bad);
    op_row_t row;
    row.op.func              = f;
    row.op.operand           = opnd;
    row.typed                = typed;
    row.want.acc_out         = acc;
    row.want.incdec_value    = idv;
    row.want.flags_out       = fl;
    row.want.bad_code        = bad;
    op_table.push_back(row);
  endtask

  // One ALU operation against the model accumulator and flags.
  function automatic aalu_out_t alu_predict(input aalu_in_t op);
    logic [8:0] sum;
    logic [4:0] nib;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic [7:0] idv;
    logic [3:0] fl;
    logic       cin;
    logic       cy;
    logic       bad;
    aalu_out_t  res;
    a   = acc_q;
    b   = op.operand;
    cin = flag_q[FLAG_C];
    fl  = flag_q;
    idv = 8'h00;
    bad = 1'b0;
    case (op.func)
      FUNC_ADD, FUNC_ADC: begin
        cy  = (op.func == FUNC_ADC) & cin;
        sum = {1'b0, a} + {1'b0, b} + {8'b0, cy};
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cy};
        acc_q      = sum[7:0];
        fl[FLAG_Z] = (sum[7:0] == 8'h00);
        fl[FLAG_N] = 1'b0;
        fl[FLAG_H] = nib[4];
        fl[FLAG_C] = sum[8];
      end
      FUNC_SUB, FUNC_SBC, FUNC_CP: begin
        // bit 8 / bit 4 of the wrapped difference is the borrow
        cy  = (op.func == FUNC_SBC) & cin;
        sum = {1'b0, a} - {1'b0, b} - {8'b0, cy};
        nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cy};
        if (op.func != FUNC_CP) begin
          acc_q = sum[7:0];
        end
        fl[FLAG_Z] = (sum[7:0] == 8'h00);
        fl[FLAG_N] = 1'b1;
        fl[FLAG_H] = nib[4];
        fl[FLAG_C] = sum[8];
      end
      FUNC_AND, FUNC_XOR: begin
        r          = (op.func == FUNC_AND) ? (a & b) : (a ^ b);
        acc_q      = r;
        fl[FLAG_Z] = (r == 8'h00);
        fl[FLAG_N] = 1'b0;
        fl[FLAG_H] = (op.func == FUNC_AND);
        fl[FLAG_C] = 1'b0;
      end
      FUNC_INC: begin
        idv        = b + 8'd1;
        fl[FLAG_Z] = (idv == 8'h00);
        fl[FLAG_N] = 1'b0;
        fl[FLAG_H] = (b[3:0] == 4'hF);
      end
      FUNC_DEC: begin
        idv        = b - 8'd1;
        fl[FLAG_Z] = (idv == 8'h00);
        fl[FLAG_N] = 1'b1;
        fl[FLAG_H] = (b[3:0] == 4'h0);
      end
      FUNC_CPL: begin
        acc_q      = ~a;
        fl[FLAG_N] = 1'b1;
        fl[FLAG_H] = 1'b1;
      end
      FUNC_SCF: begin
        fl[FLAG_N] = 1'b0;
        fl[FLAG_H] = 1'b0;
        fl[FLAG_C] = 1'b1;
      end
      FUNC_CCF: begin
        fl[FLAG_N] = 1'b0;
        fl[FLAG_H] = 1'b0;
        fl[FLAG_C] = ~cin;
      end
      default: begin
        bad = 1'b1;   // state untouched
      end
    endcase
    flag_q           = fl;
    res.acc_out      = acc_q;
    res.incdec_value = idv;
    res.flags_out    = flag_q;
    res.bad_code     = bad;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the DUT's
  // own updates land, so both channels see pre-edge values.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    aalu_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = alu_predict(in_data);
        if (n_taken < op_table.size() && op_table[n_taken].typed) begin
          want = op_table[n_taken].want;
        end
        result_q.push_back(want);
        n_taken = n_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing pending: %h", out_data);
          n_errors = n_errors + 1;
        end else begin
          want = result_q.pop_front();
          if (out_data.acc_out !== want.acc_out) begin
            $error("acc_out: expected %0h, got %0h", want.acc_out, out_data.acc_out);
            n_errors = n_errors + 1;
          end
          if (out_data.incdec_value !== want.incdec_value) begin
            $error("incdec_value: expected %0h, got %0h",
                   want.incdec_value, out_data.incdec_value);
            n_errors = n_errors + 1;
          end
          if (out_data.flags_out !== want.flags_out) begin
            $error("flags_out: expected %0h, got %0h", want.flags_out, out_data.flags_out);
            n_errors = n_errors + 1;
          end
          if (out_data.bad_code !== want.bad_code) begin
            $error("bad_code: expected %0h, got %0h", want.bad_code, out_data.bad_code);
            n_errors = n_errors + 1;
          end
        end
      end
    end
  end

  // Watchdog: no transaction on either side for too long means a hang.
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure: switches between a few stall densities,
  // including stretches with no stall at all.
  initial begin : result_stall
    int mode;
    int len;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(16, 96);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 15) != 0);  // long stall runs
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  // Present one transaction and hold it until it is taken.
  task automatic send_op(input aalu_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // Burst/gap pacing; called before each transaction.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
  endtask

  // Stop sending until every pending result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    aalu_in_t item;
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    n_taken    = 0;
    n_errors   = 0;
    burst_left = 0;
    acc_q      = 8'h00;
    flag_q     = 4'h0;

    // Starts from reset: A=00, flags=0. Flags column is Z N H C.
    add_row(FUNC_INC,   8'hFF, 1'b1, 8'h00, 8'h00, 4'hA, 1'b0);  // inc wraps to zero
    add_row(FUNC_DEC,   8'h00, 1'b1, 8'h00, 8'hFF, 4'h6, 1'b0);  // dec wraps to FF
    add_row(FUNC_ADD,   8'h00, 1'b1, 8'h00, 8'h00, 4'h8, 1'b0);
    add_row(FUNC_RSV12, 8'h00, 1'b1, 8'h00, 8'h00, 4'h8, 1'b1);  // unused code keeps state
    add_row(FUNC_ADD,   8'hFF, 1'b1, 8'hFF, 8'h00, 4'h0, 1'b0);
    add_row(FUNC_ADD,   8'h01, 1'b1, 8'h00, 8'h00, 4'hB, 1'b0);  // full carry chain
    add_row(FUNC_ADC,   8'hFF, 1'b1, 8'h00, 8'h00, 4'hB, 1'b0);  // carry in used
    add_row(FUNC_SBC,   8'h00, 1'b1, 8'hFF, 8'h00, 4'h7, 1'b0);  // borrow in used
    add_row(FUNC_SUB,   8'hFF, 1'b1, 8'h00, 8'h00, 4'hC, 1'b0);
    add_row(FUNC_CP,    8'h01, 1'b1, 8'h00, 8'h00, 4'h7, 1'b0);  // A untouched
    add_row(FUNC_CCF,   8'h00, 1'b1, 8'h00, 8'h00, 4'h0, 1'b0);
    add_row(FUNC_SCF,   8'h00, 1'b1, 8'h00, 8'h00, 4'h1, 1'b0);
    add_row(FUNC_CPL,   8'h00, 1'b1, 8'hFF, 8'h00, 4'h7, 1'b0);
    add_row(FUNC_AND,   8'h00, 1'b1, 8'h00, 8'h00, 4'hA, 1'b0);
    add_row(FUNC_XOR,   8'hFF, 1'b1, 8'hFF, 8'h00, 4'h0, 1'b0);
    add_row(FUNC_AND,   8'hFF, 1'b1, 8'hFF, 8'h00, 4'h2, 1'b0);
    add_row(FUNC_INC,   8'h0F, 1'b1, 8'hFF, 8'h10, 4'h2, 1'b0);  // nibble carry
    add_row(FUNC_DEC,   8'h10, 1'b1, 8'hFF, 8'h0F, 4'h6, 1'b0);  // nibble borrow
    add_row(FUNC_RSV15, 8'hAA, 1'b1, 8'hFF, 8'h00, 4'h6, 1'b1);
    add_row(FUNC_SCF,   8'h00, 1'b1, 8'hFF, 8'h00, 4'h1, 1'b0);
    add_row(FUNC_ADC,   8'h00, 1'b1, 8'h00, 8'h00, 4'hB, 1'b0);
    add_row(FUNC_SBC,   8'h0F, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0);
    add_row(FUNC_XOR,   8'h5A, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0);
    add_row(FUNC_CP,    8'hA5, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0);
    add_row(FUNC_RSV13, 8'h33, 1'b0, 8'h00, 8'h00, 4'h0, 1'b0);

    // synchronous reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (op_table[i]) begin
      pace();
      send_op(op_table[i].op);
    end
    drain_results();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      pace();
      if ($urandom_range(0, 99) < 8) begin
        item.func = 4'($urandom_range(FUNC_RSV12, FUNC_RSV15));
      end else begin
        item.func = 4'($urandom_range(FUNC_ADD, FUNC_CCF));
      end
      // bias toward carry/borrow boundaries now and then
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 5))
          0: item.operand = 8'h00;
          1: item.operand = 8'hFF;
          2: item.operand = 8'h0F;
          3: item.operand = 8'h10;
          4: item.operand = 8'h80;
          default: item.operand = 8'h7F;
        endcase
      end else begin
        item.operand = 8'($urandom_range(0, 255));
      end
      send_op(item);
      if (n == DRAIN_AT) begin
        drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
